>>> design/edist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edist_pkg
// Shared constants, codes and control types of the edit distance engine.
// ----------------------------------------------------------------------------
package edist_pkg;

    localparam int MAX_LEN   = 256;
    localparam int ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int ROW_DEPTH = MAX_LEN + 1;
    localparam int DIST_W    = 9;
    localparam int FRAC_W    = 16;
    localparam int SIM_W     = 17;
    localparam int NUM_W     = LEN_W + FRAC_W;
    localparam int DCNT_W    = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {
        KIND_APPEND_A = 2'd0,
        KIND_APPEND_B = 2'd1,
        KIND_COMPUTE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW_RD,
        ST_ROW_SET,
        ST_CELL_RD,
        ST_CELL_WR,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic init_start;
        logic init_step;
        logic row_rd;
        logic row_set;
        logic cell_rd;
        logic cell_wr;
        logic div_start;
        logic div_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic bad;        // overflow seen or a string empty
        logic j_last;     // column index has reached length_b
        logic i_last;     // row index has reached length_a
        logic div_last;   // final divider step
    } ctrl_sts_t;

endpackage

>>> design/edit_distance_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_engine
// Levenshtein edit distance and similarity of two loaded byte strings.
// ----------------------------------------------------------------------------
// Channel  | Handshake            | Payload
// input    | start && !busy       | kind, byte_value
// result   | done (one cycle)     | status, distance, similarity
//
// A load beat leaves busy low. A compute beat with an empty or overflowed
// string returns its result in the next cycle. Otherwise it initializes row
// zero, then walks each row of string A cell by cell through the single-port
// row store, then runs the bit-serial divider and presents the result. Reset
// is asynchronous and clears the lengths and the overflow flag; the result
// strobe cannot be stalled.
// ----------------------------------------------------------------------------
module edit_distance_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    kind,
    input  logic [7:0]                    byte_value,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [edist_pkg::DIST_W-1:0]  distance,
    output logic [edist_pkg::SIM_W-1:0]   similarity
);

    edist_pkg::ctrl_cmd_t cmd;
    edist_pkg::ctrl_sts_t sts;
    logic                 busy_int;

    edist_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy_int)
    );

    edist_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .byte_value (byte_value),
        .sts        (sts),
        .done       (done),
        .status     (status),
        .distance   (distance),
        .similarity (similarity)
    );

    assign busy = busy_int;

endmodule

>>> design/edist_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edist_ctrl
// Sequencer: decodes input beats and steps the datapath through row
// initialization, the cell recurrence and the similarity divide.
// ----------------------------------------------------------------------------
module edist_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            kind,
    input  edist_pkg::ctrl_sts_t  sts,
    output edist_pkg::ctrl_cmd_t  cmd,
    output logic                  busy
);

    edist_pkg::state_t state_reg;
    edist_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= edist_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            edist_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        edist_pkg::KIND_APPEND_A: cmd.load_a = 1'b1;
                        edist_pkg::KIND_APPEND_B: cmd.load_b = 1'b1;
                        edist_pkg::KIND_COMPUTE:
                        begin
                            if (sts.bad)
                            begin
                                cmd.emit = 1'b1;
                            end
                            else
                            begin
                                cmd.init_start = 1'b1;
                                state_next     = edist_pkg::ST_INIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            edist_pkg::ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.j_last)
                begin
                    state_next = edist_pkg::ST_ROW_RD;
                end
            end
            edist_pkg::ST_ROW_RD:
            begin
                cmd.row_rd = 1'b1;
                state_next = edist_pkg::ST_ROW_SET;
            end
            edist_pkg::ST_ROW_SET:
            begin
                cmd.row_set = 1'b1;
                state_next  = edist_pkg::ST_CELL_RD;
            end
            edist_pkg::ST_CELL_RD:
            begin
                cmd.cell_rd = 1'b1;
                state_next  = edist_pkg::ST_CELL_WR;
            end
            edist_pkg::ST_CELL_WR:
            begin
                cmd.cell_wr = 1'b1;
                if (!sts.j_last)
                begin
                    state_next = edist_pkg::ST_CELL_RD;
                end
                else if (!sts.i_last)
                begin
                    state_next = edist_pkg::ST_ROW_RD;
                end
                else
                begin
                    state_next = edist_pkg::ST_DIV;
                end
            end
            edist_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = edist_pkg::ST_FINISH;
                end
            end
            edist_pkg::ST_FINISH:
            begin
                cmd.emit   = 1'b1;
                state_next = edist_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = edist_pkg::ST_IDLE;
            end
        endcase
        // The divider is loaded while the last cell is written back.
        cmd.div_start = (state_reg == edist_pkg::ST_CELL_WR) && sts.j_last && sts.i_last;
    end

    assign busy = (state_reg != edist_pkg::ST_IDLE);

endmodule

>>> design/edist_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edist_dp
// Datapath: string stores, the single row store, the cell update and a
// restoring divider for the similarity, plus the result registers.
// ----------------------------------------------------------------------------
module edist_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  edist_pkg::ctrl_cmd_t          cmd,
    input  logic [7:0]                    byte_value,
    output edist_pkg::ctrl_sts_t          sts,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [edist_pkg::DIST_W-1:0]  distance,
    output logic [edist_pkg::SIM_W-1:0]   similarity
);

    localparam int LW = edist_pkg::LEN_W;
    localparam int NW = edist_pkg::NUM_W;
    localparam int AW = edist_pkg::ADDR_W;
    localparam int CW = edist_pkg::DCNT_W;

    logic [7:0]    mem_a [edist_pkg::MAX_LEN];
    logic [7:0]    mem_b [edist_pkg::MAX_LEN];
    logic [LW-1:0] mem_row [edist_pkg::ROW_DEPTH];

    logic [LW-1:0] len_a_reg, len_a_next;
    logic [LW-1:0] len_b_reg, len_b_next;
    logic          ovf_reg, ovf_next;
    logic [LW-1:0] i_reg, i_next;
    logic [LW-1:0] j_reg, j_next;
    logic [LW-1:0] diag_reg, diag_next;
    logic [LW-1:0] left_reg, left_next;
    logic [7:0]    ca_reg, ca_next;
    logic [NW-1:0] num_reg, num_next;
    logic [LW-1:0] rem_reg, rem_next;
    logic [CW-1:0] dcnt_reg, dcnt_next;
    logic          done_reg, done_next;
    logic [1:0]    status_reg, status_next;
    logic [edist_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic [edist_pkg::SIM_W-1:0]  sim_reg, sim_next;

    logic [7:0]    a_rdata_reg;
    logic [7:0]    b_rdata_reg;
    logic [LW-1:0] up_rdata_reg;

    logic          row_we;
    logic [LW-1:0] row_waddr;
    logic [LW-1:0] row_wdata;
    logic [LW-1:0] longer;
    logic          empty;
    logic [LW:0]   cand_up, cand_left, cand_diag, cell_min;
    logic [LW:0]   rem_sh;

    assign longer = (len_a_reg > len_b_reg) ? len_a_reg : len_b_reg;
    assign empty  = (len_a_reg == '0) || (len_b_reg == '0);

    // Cell recurrence: min(up + 1, left + 1, diag + mismatch).
    always_comb
    begin
        cand_up   = {1'b0, up_rdata_reg} + 1'b1;
        cand_left = {1'b0, left_reg} + 1'b1;
        cand_diag = {1'b0, diag_reg} + {{LW{1'b0}}, (ca_reg != b_rdata_reg)};
        cell_min  = (cand_up < cand_left) ? cand_up : cand_left;
        if (cand_diag < cell_min)
        begin
            cell_min = cand_diag;
        end
    end

    assign rem_sh = {rem_reg, num_reg[NW-1]};

    always_comb
    begin
        len_a_next  = len_a_reg;
        len_b_next  = len_b_reg;
        ovf_next    = ovf_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        diag_next   = diag_reg;
        left_next   = left_reg;
        ca_next     = ca_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        dist_next   = dist_reg;
        sim_next    = sim_reg;
        row_we      = 1'b0;
        row_waddr   = j_reg;
        row_wdata   = j_reg;

        if (cmd.load_a)
        begin
            if (len_a_reg < LW'(edist_pkg::MAX_LEN))
            begin
                len_a_next = len_a_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.load_b)
        begin
            if (len_b_reg < LW'(edist_pkg::MAX_LEN))
            begin
                len_b_next = len_b_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.init_start)
        begin
            j_next = '0;
            i_next = LW'(1);
        end
        if (cmd.init_step)
        begin
            row_we = 1'b1;
            j_next = j_reg + 1'b1;
        end
        if (cmd.row_set)
        begin
            ca_next   = a_rdata_reg;
            diag_next = i_reg - 1'b1;
            left_next = i_reg;
            row_we    = 1'b1;
            row_waddr = '0;
            row_wdata = i_reg;
            j_next    = LW'(1);
        end
        if (cmd.cell_wr)
        begin
            row_we    = 1'b1;
            row_wdata = cell_min[LW-1:0];
            left_next = cell_min[LW-1:0];
            diag_next = up_rdata_reg;
            if (j_reg == len_b_reg)
            begin
                i_next = i_reg + 1'b1;
            end
            else
            begin
                j_next = j_reg + 1'b1;
            end
        end
        if (cmd.div_start)
        begin
            // The final cell value is the distance.
            num_next  = {longer - cell_min[LW-1:0], {edist_pkg::FRAC_W{1'b0}}};
            rem_next  = '0;
            dcnt_next = '0;
            dist_next = edist_pkg::DIST_W'(cell_min[LW-1:0]);
        end
        if (cmd.div_step)
        begin
            dcnt_next = dcnt_reg + 1'b1;
            if (rem_sh >= {1'b0, longer})
            begin
                rem_next = LW'(rem_sh - {1'b0, longer});
                num_next = {num_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[LW-1:0];
                num_next = {num_reg[NW-2:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            done_next = 1'b1;
            if (ovf_reg)
            begin
                status_next = edist_pkg::STATUS_OVERFLOW;
                dist_next   = '0;
                sim_next    = '0;
            end
            else if (empty)
            begin
                status_next = edist_pkg::STATUS_EMPTY;
                dist_next   = '0;
                sim_next    = '0;
            end
            else
            begin
                status_next = edist_pkg::STATUS_OK;
                sim_next    = num_reg[edist_pkg::SIM_W-1:0];
            end
            len_a_next = '0;
            len_b_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg <= '0;
            len_b_reg <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
            dcnt_reg  <= '0;
        end
        else
        begin
            len_a_reg <= len_a_next;
            len_b_reg <= len_b_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        diag_reg   <= diag_next;
        left_reg   <= left_next;
        ca_reg     <= ca_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        status_reg <= status_next;
        dist_reg   <= dist_next;
        sim_reg    <= sim_next;
    end

    // String stores.
    always_ff @(posedge clk)
    begin
        if (cmd.load_a && (len_a_reg < LW'(edist_pkg::MAX_LEN)))
        begin
            mem_a[len_a_reg[AW-1:0]] <= byte_value;
        end
        if (cmd.load_b && (len_b_reg < LW'(edist_pkg::MAX_LEN)))
        begin
            mem_b[len_b_reg[AW-1:0]] <= byte_value;
        end
        if (cmd.row_rd)
        begin
            a_rdata_reg <= mem_a[AW'(i_reg - 1'b1)];
        end
        if (cmd.cell_rd)
        begin
            b_rdata_reg <= mem_b[AW'(j_reg - 1'b1)];
        end
    end

    // Row store.
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            mem_row[row_waddr] <= row_wdata;
        end
        if (cmd.cell_rd)
        begin
            up_rdata_reg <= mem_row[j_reg];
        end
    end

    assign sts.bad      = ovf_reg || empty;
    assign sts.j_last   = (j_reg == len_b_reg);
    assign sts.i_last   = (i_reg == len_a_reg);
    assign sts.div_last = (dcnt_reg == CW'(NW - 1));

    assign done       = done_reg;
    assign status     = status_reg;
    assign distance   = dist_reg;
    assign similarity = sim_reg;

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg != edist_pkg::STATUS_OK) |-> (dist_reg == '0) && (sim_reg == '0))
        else $error("error result carries nonzero payload");
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> done_reg)
        else $error("emit did not raise done");
    a_cell_col: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cell_wr |-> (j_reg != '0))
        else $error("cell write at column zero");
    a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == edist_pkg::STATUS_OK) |-> (sim_reg <= 17'd65536))
        else $error("similarity above one");
`endif

endmodule

>>> tb/tb_edit_distance_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edit_distance_engine
// Self-checking bench for the edit distance engine: loads byte strings,
// predicts distance, similarity and status on each compute beat, and
// compares every result strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_edit_distance_engine;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         STALL_LIMIT = 1000000;

    typedef struct {
        edist_pkg::status_t                status;
        logic [edist_pkg::DIST_W-1:0]      distance;
        logic [edist_pkg::SIM_W-1:0]       similarity;
    } edist_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [1:0]                     kind;
    logic [7:0]                     byte_value;
    logic                           done;
    logic [1:0]                     status;
    logic [edist_pkg::DIST_W-1:0]   distance;
    logic [edist_pkg::SIM_W-1:0]    similarity;

    edit_distance_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .byte_value (byte_value),
        .done       (done),
        .status     (status),
        .distance   (distance),
        .similarity (similarity)
    );

    // Shadow copy of the engine's strings and flags.
    logic [7:0]      str_a [edist_pkg::MAX_LEN];
    logic [7:0]      str_b [edist_pkg::MAX_LEN];
    int              len_a;
    int              len_b;
    bit              overflowed;
    edist_result_t   pending_results[$];

    int  beats_sent;
    int  results_seen;
    int  ok_results;
    int  empty_results;
    int  overflow_results;
    int  mismatches;
    int  stall_cycles;
    bit  idle_enabled;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int levenshtein_distance();
        int row [edist_pkg::MAX_LEN + 1];
        int diag;
        int up;
        int v;
        for (int j = 0; j <= len_b; j++)
            row[j] = j;
        for (int i = 1; i <= len_a; i++)
        begin
            diag = row[0];
            row[0] = i;
            for (int j = 1; j <= len_b; j++)
            begin
                up = row[j];
                v = (up < row[j-1]) ? up + 1 : row[j-1] + 1;
                if (diag + ((str_a[i-1] == str_b[j-1]) ? 0 : 1) < v)
                    v = diag + ((str_a[i-1] == str_b[j-1]) ? 0 : 1);
                diag = up;
                row[j] = v;
            end
        end
        return row[len_b];
    endfunction

    task automatic predict_beat(input logic [1:0] k, input logic [7:0] b);
        edist_result_t r;
        int            longer;
        int            dist_val;
        longint        num;
        if (k == edist_pkg::KIND_APPEND_A || k == edist_pkg::KIND_APPEND_B)
        begin
            if (k == edist_pkg::KIND_APPEND_A && len_a < edist_pkg::MAX_LEN)
            begin
                str_a[len_a] = b;
                len_a++;
            end
            else if (k == edist_pkg::KIND_APPEND_B && len_b < edist_pkg::MAX_LEN)
            begin
                str_b[len_b] = b;
                len_b++;
            end
            else
                overflowed = 1'b1;
        end
        else if (k == edist_pkg::KIND_COMPUTE)
        begin
            r.status = edist_pkg::STATUS_OK;
            r.distance = '0;
            r.similarity = '0;
            if (overflowed)
                r.status = edist_pkg::STATUS_OVERFLOW;
            else if (len_a == 0 || len_b == 0)
                r.status = edist_pkg::STATUS_EMPTY;
            else
            begin
                longer = (len_a > len_b) ? len_a : len_b;
                dist_val = levenshtein_distance();
                num = longint'(longer - dist_val) << edist_pkg::FRAC_W;
                r.distance = dist_val[edist_pkg::DIST_W-1:0];
                r.similarity = edist_pkg::SIM_W'(num / longer);
            end
            len_a = 0;
            len_b = 0;
            overflowed = 1'b0;
            pending_results.push_back(r);
        end
    endtask

    // Drives one beat at the falling edge and holds it until the engine takes it.
    task automatic send_beat(input logic [1:0] k, input logic [7:0] b);
        int gap;
        if (idle_enabled && $urandom_range(0, 99) < 13)
        begin
            gap = $urandom_range(1, 2);
            @(negedge clk);
            start <= 1'b0;
            kind <= 2'($urandom);
            byte_value <= 8'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        kind <= k;
        byte_value <= b;
        do
            @(posedge clk);
        while (busy);
        predict_beat(k, b);
        beats_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic wait_for_results();
        stop_sending();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_string(input logic [1:0] k, input int n, input int alphabet);
        for (int i = 0; i < n; i++)
            send_beat(k, 8'($urandom_range(0, alphabet - 1)));
    endtask

    task automatic test_corner_cases();
        // Single bytes at both extremes, equal and different.
        send_beat(edist_pkg::KIND_APPEND_A, 8'h00);
        send_beat(edist_pkg::KIND_APPEND_B, 8'h00);
        send_beat(edist_pkg::KIND_COMPUTE, 8'hFF);
        send_beat(edist_pkg::KIND_APPEND_A, 8'hFF);
        send_beat(edist_pkg::KIND_APPEND_B, 8'h00);
        send_beat(edist_pkg::KIND_COMPUTE, 8'h00);
        // Empty B, empty A, both empty.
        send_beat(edist_pkg::KIND_APPEND_A, 8'hAA);
        send_beat(edist_pkg::KIND_COMPUTE, 8'h55);
        send_beat(edist_pkg::KIND_APPEND_B, 8'h55);
        send_beat(edist_pkg::KIND_COMPUTE, 8'h00);
        send_beat(edist_pkg::KIND_COMPUTE, 8'h00);
        // The unused kind must leave the strings alone and give no result.
        send_beat(edist_pkg::KIND_APPEND_A, 8'h12);
        send_beat(KIND_UNUSED, 8'hFF);
        send_beat(edist_pkg::KIND_APPEND_B, 8'h21);
        send_beat(KIND_UNUSED, 8'h00);
        send_beat(edist_pkg::KIND_APPEND_B, 8'h12);
        send_beat(edist_pkg::KIND_COMPUTE, 8'h00);
    endtask

    task automatic test_full_strings();
        load_string(edist_pkg::KIND_APPEND_A, edist_pkg::MAX_LEN, 256);
        load_string(edist_pkg::KIND_APPEND_B, edist_pkg::MAX_LEN, 2);
        send_beat(edist_pkg::KIND_COMPUTE, 8'h00);
        load_string(edist_pkg::KIND_APPEND_A, edist_pkg::MAX_LEN, 1);
        send_beat(edist_pkg::KIND_APPEND_B, 8'h00);
        send_beat(edist_pkg::KIND_COMPUTE, 8'h00);
        // One byte past full sets the overflow flag.
        load_string(edist_pkg::KIND_APPEND_A, edist_pkg::MAX_LEN + 1, 256);
        load_string(edist_pkg::KIND_APPEND_B, 2, 256);
        send_beat(edist_pkg::KIND_COMPUTE, 8'h00);
        // Overflow wins over an empty string.
        load_string(edist_pkg::KIND_APPEND_B, edist_pkg::MAX_LEN + 3, 256);
        send_beat(edist_pkg::KIND_COMPUTE, 8'h00);
        // The flag must be gone after the compute beat.
        send_beat(edist_pkg::KIND_APPEND_A, 8'h7F);
        send_beat(edist_pkg::KIND_APPEND_B, 8'h80);
        send_beat(edist_pkg::KIND_COMPUTE, 8'h00);
    endtask

    task automatic test_random_pairs(input int target_beats);
        int na;
        int nb;
        int alphabet;
        int pick;
        while (beats_sent < target_beats)
        begin
            pick = $urandom_range(0, 99);
            na = (pick < 5) ? 0 : (pick < 10) ? $urandom_range(13, 40)
                                               : $urandom_range(1, 12);
            pick = $urandom_range(0, 99);
            nb = (pick < 5) ? 0 : (pick < 10) ? $urandom_range(13, 40)
                                               : $urandom_range(1, 12);
            alphabet = ($urandom_range(0, 1) != 0) ? 4 : 256;
            // Interleave the two strings' loads in random order.
            while (na > 0 || nb > 0)
            begin
                if ($urandom_range(0, 99) < 3)
                    send_beat(KIND_UNUSED, 8'($urandom));
                if (nb == 0 || (na > 0 && $urandom_range(0, 1) != 0))
                begin
                    send_beat(edist_pkg::KIND_APPEND_A,
                              8'($urandom_range(0, alphabet - 1)));
                    na--;
                end
                else
                begin
                    send_beat(edist_pkg::KIND_APPEND_B,
                              8'($urandom_range(0, alphabet - 1)));
                    nb--;
                end
            end
            send_beat(edist_pkg::KIND_COMPUTE, 8'($urandom));
        end
    endtask

    always @(posedge clk)
    begin
        edist_result_t exp_r;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result status=%0d distance=%0d similarity=%0d",
                             status, distance, similarity);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                case (exp_r.status)
                    edist_pkg::STATUS_OK:       ok_results++;
                    edist_pkg::STATUS_EMPTY:    empty_results++;
                    edist_pkg::STATUS_OVERFLOW: overflow_results++;
                    default:                    ;
                endcase
                if (status !== exp_r.status || distance !== exp_r.distance ||
                    similarity !== exp_r.similarity)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: expected status=%0d distance=%0d ",
                                  "similarity=%0d, got %0d %0d %0d"},
                                 exp_r.status, exp_r.distance, exp_r.similarity,
                                 status, distance, similarity);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        kind = edist_pkg::KIND_APPEND_A;
        byte_value = 8'h00;
        len_a = 0;
        len_b = 0;
        overflowed = 1'b0;
        beats_sent = 0;
        results_seen = 0;
        ok_results = 0;
        empty_results = 0;
        overflow_results = 0;
        mismatches = 0;
        stall_cycles = 0;
        idle_enabled = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_corner_cases();
        test_full_strings();
        wait_for_results();
        test_random_pairs(beats_sent + 100);
        idle_enabled = 1'b0;
        test_random_pairs(beats_sent + 80);
        idle_enabled = 1'b1;
        test_random_pairs(beats_sent + 60);

        wait_for_results();
        repeat (40) @(posedge clk);
        $display("Covered %0d beats and %0d results: %0d ok, %0d empty, %0d overflow.",
                 beats_sent, results_seen, ok_results, empty_results, overflow_results);
        $display("Full-length strings, overflow, unused kind and idle gaps were exercised.");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
design/edist_pkg.sv
design/edist_ctrl.sv
design/edist_dp.sv
design/edit_distance_engine.sv
tb/tb_edit_distance_engine.sv
